/* src/svt_pkg.sv */
// svt_pkg: shared types and constants of the scoped variable table
// holds the operation codes, status codes, state encoding and the
// command/status structs between controller and datapath; no dependencies
package svt_pkg;

    // fixed field widths
    localparam int MODE_W  = 3;
    localparam int KEY_W   = 64;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int LEVEL_W = 8;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    // operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH      = 3'd0,
        MODE_POP       = 3'd1,
        MODE_SET_LOCAL = 3'd2,
        MODE_SET_ARG   = 3'd3,
        MODE_SET_PLAIN = 3'd4,
        MODE_GET       = 3'd5
    } t_mode;

    // status codes
    typedef logic [STAT_W-1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_OVER  = 2'd2;
    localparam t_status ST_UNDER = 2'd3;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_POP,
        S_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    scan_start;
        logic    scan_step;
        logic    lvl_inc;
        logic    lvl_dec;
        logic    append;
        logic    arg_level;
        logic    update;
        logic    set_found;
        logic    cnt_pop;
        logic    status_we;
        t_status status;
        logic    out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_mode mode;
        logic  lvl_max;
        logic  lvl_zero;
        logic  full;
        logic  rd_vld;
        logic  key_hit;
        logic  lvl_hit;
        logic  exhausted;
        logic  out_free;
    } t_stat;

endpackage

/* src/svt_datapath.sv */
// svt_datapath: entry memory, count and level registers, scan pointer
// and result/output registers of the scoped variable table
// depends on svt_pkg; driven by svt_ctrl through t_cmd
module svt_datapath #(
    parameter int TABLE_ENTRIES = 64,
    parameter int NAME_BYTES    = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  svt_pkg::t_cmd                       i_cmd,
    output svt_pkg::t_stat                      o_stat,
    input  logic [svt_pkg::MODE_W-1:0]          i_mode,
    input  logic [svt_pkg::KEY_W-1:0]           i_name_key,
    input  logic signed [svt_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_found,
    output logic signed [svt_pkg::VALUE_W-1:0]  o_read_value,
    output logic [svt_pkg::STAT_W-1:0]          o_status
);

    localparam int NW = NAME_BYTES * 8;
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int LW = svt_pkg::LEVEL_W;
    localparam int VW = svt_pkg::VALUE_W;

    // entry memory, one read and one write per cycle
    logic [NW-1:0] mem_name  [TABLE_ENTRIES];
    logic [VW-1:0] mem_value [TABLE_ENTRIES];
    logic [LW-1:0] mem_level [TABLE_ENTRIES];

    logic [CW-1:0]  r_count, n_count;
    logic [LW-1:0]  r_level, n_level;
    svt_pkg::t_mode r_mode;
    logic [NW-1:0]  r_key;
    logic [VW-1:0]  r_value;
    logic [CW-1:0]  r_ptr;
    logic           r_rd_vld;
    logic [AW-1:0]  r_rd_idx;
    logic [NW-1:0]  r_rd_name;
    logic [VW-1:0]  r_rd_value;
    logic [LW-1:0]  r_rd_level;
    logic           r_found;
    logic [VW-1:0]  r_rdval;
    svt_pkg::t_status r_status;
    logic           r_out_valid;
    logic           r_out_found;
    logic [VW-1:0]  r_out_rdval;
    svt_pkg::t_status r_out_status;

    logic [CW-1:0] ptr_dec;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] app_addr;
    logic [LW-1:0] app_level;
    logic          lvl_match;
    logic          out_free;

    assign ptr_dec   = r_ptr - 1'b1;
    assign rd_addr   = ptr_dec[AW-1:0];
    assign app_addr  = r_count[AW-1:0];
    assign app_level = i_cmd.arg_level ? (r_level + 1'b1) : r_level;
    assign lvl_match = (r_rd_level == r_level);
    assign out_free  = !r_out_valid || !i_out_stall;

    // status back to the controller
    always_comb begin
        o_stat.mode      = r_mode;
        o_stat.lvl_max   = (r_level == svt_pkg::LEVEL_MAX);
        o_stat.lvl_zero  = (r_level == '0);
        o_stat.full      = (r_count == CW'(TABLE_ENTRIES));
        o_stat.rd_vld    = r_rd_vld;
        o_stat.key_hit   = r_rd_vld && lvl_match && (r_rd_name == r_key);
        o_stat.lvl_hit   = r_rd_vld && lvl_match;
        o_stat.exhausted = !r_rd_vld && (r_ptr == '0);
        o_stat.out_free  = out_free;
    end

    // memory write port: append at the count, or value update at the hit
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            mem_name[app_addr]  <= r_key;
            mem_value[app_addr] <= r_value;
            mem_level[app_addr] <= app_level;
        end else if (i_cmd.update) begin
            mem_value[r_rd_idx] <= r_value;
        end
    end

    // memory read port, registered data
    always_ff @(posedge i_clk) begin
        r_rd_name  <= mem_name[rd_addr];
        r_rd_value <= mem_value[rd_addr];
        r_rd_level <= mem_level[rd_addr];
    end

    // next count and level
    always_comb begin
        n_count = r_count;
        if (i_cmd.append) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.cnt_pop) begin
            n_count = {{(CW-AW){1'b0}}, r_rd_idx};
        end
        n_level = r_level;
        if (i_cmd.lvl_inc) begin
            n_level = r_level + 1'b1;
        end else if (i_cmd.lvl_dec) begin
            n_level = r_level - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_level     <= '0;
            r_rd_vld    <= 1'b0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_level <= n_level;
            // scan pointer walks newest to oldest, one entry a cycle
            if (i_cmd.scan_start) begin
                r_ptr    <= r_count;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= (r_ptr != '0);
                if (r_ptr != '0) begin
                    r_ptr <= ptr_dec;
                end
            end else begin
                r_rd_vld <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_rd_idx <= rd_addr;
        end
        if (i_cmd.capture) begin
            r_mode   <= svt_pkg::t_mode'(i_mode);
            r_key    <= i_name_key[NW-1:0];
            r_value  <= $unsigned(i_value);
            r_found  <= 1'b0;
            r_rdval  <= '0;
            r_status <= svt_pkg::ST_OK;
        end else begin
            if (i_cmd.set_found) begin
                r_found <= 1'b1;
                r_rdval <= r_rd_value;
            end
            if (i_cmd.status_we) begin
                r_status <= i_cmd.status;
            end
        end
        if (i_cmd.out_load) begin
            r_out_found  <= r_found;
            r_out_rdval  <= r_rdval;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_out_found;
    assign o_read_value = $signed(r_out_rdval);
    assign o_status     = r_out_status;

endmodule

/* src/svt_ctrl.sv */
// svt_ctrl: controller state machine of the scoped variable table
// sequences decode, table scans, pops and result hand-off
// depends on svt_pkg; commands svt_datapath
module svt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  svt_pkg::t_stat i_stat,
    output svt_pkg::t_cmd  o_cmd
);

    svt_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= svt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            svt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = svt_pkg::S_DECODE;
                end
            end
            svt_pkg::S_DECODE: begin
                case (i_stat.mode)
                    svt_pkg::MODE_POP: begin
                        n_state = i_stat.lvl_zero ? svt_pkg::S_FINISH : svt_pkg::S_POP;
                    end
                    svt_pkg::MODE_SET_LOCAL, svt_pkg::MODE_GET: begin
                        n_state = svt_pkg::S_SCAN;
                    end
                    default: begin
                        n_state = svt_pkg::S_FINISH;
                    end
                endcase
            end
            svt_pkg::S_SCAN: begin
                if (i_stat.key_hit || i_stat.exhausted) begin
                    n_state = svt_pkg::S_FINISH;
                end
            end
            svt_pkg::S_POP: begin
                if (!i_stat.lvl_hit && (i_stat.rd_vld || i_stat.exhausted)) begin
                    n_state = svt_pkg::S_FINISH;
                end
            end
            svt_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = svt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = svt_pkg::S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != svt_pkg::S_IDLE);
        case (r_state)
            svt_pkg::S_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            svt_pkg::S_DECODE: begin
                case (i_stat.mode)
                    svt_pkg::MODE_PUSH: begin
                        if (i_stat.lvl_max) begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = svt_pkg::ST_OVER;
                        end else begin
                            o_cmd.lvl_inc = 1'b1;
                        end
                    end
                    svt_pkg::MODE_POP: begin
                        if (i_stat.lvl_zero) begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = svt_pkg::ST_UNDER;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                        end
                    end
                    svt_pkg::MODE_SET_LOCAL, svt_pkg::MODE_GET: begin
                        o_cmd.scan_start = 1'b1;
                    end
                    svt_pkg::MODE_SET_ARG: begin
                        if (i_stat.lvl_max) begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = svt_pkg::ST_OVER;
                        end else if (i_stat.full) begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = svt_pkg::ST_FULL;
                        end else begin
                            o_cmd.append    = 1'b1;
                            o_cmd.arg_level = 1'b1;
                        end
                    end
                    svt_pkg::MODE_SET_PLAIN: begin
                        if (i_stat.full) begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = svt_pkg::ST_FULL;
                        end else begin
                            o_cmd.append = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.status_we = 1'b0;
                    end
                endcase
            end
            svt_pkg::S_SCAN: begin
                // newest match in the current scope ends the search
                o_cmd.scan_step = 1'b1;
                if (i_stat.key_hit) begin
                    if (i_stat.mode == svt_pkg::MODE_GET) begin
                        o_cmd.set_found = 1'b1;
                    end else begin
                        o_cmd.update = 1'b1;
                    end
                end else if (i_stat.exhausted &&
                             (i_stat.mode == svt_pkg::MODE_SET_LOCAL)) begin
                    if (i_stat.full) begin
                        o_cmd.status_we = 1'b1;
                        o_cmd.status    = svt_pkg::ST_FULL;
                    end else begin
                        o_cmd.append = 1'b1;
                    end
                end
            end
            svt_pkg::S_POP: begin
                // drop the newest run at the current level, then step down
                o_cmd.scan_step = 1'b1;
                if (i_stat.lvl_hit) begin
                    o_cmd.cnt_pop = 1'b1;
                end else if (i_stat.rd_vld || i_stat.exhausted) begin
                    o_cmd.lvl_dec = 1'b1;
                end
            end
            svt_pkg::S_FINISH: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd.out_load = 1'b0;
            end
        endcase
    end

endmodule

/* src/scoped_variable_table.sv */
// scoped_variable_table: push, append, rejected and spare ops go from decode straight to the
// finish state; get, set local and pop first scan the table newest to oldest, one entry a
// cycle through the single read port, until a match, the end of the current scope (pop) or
// past the oldest entry. One item in flight; the input stalls until the result is registered,
// and output stalls hold the finish state. Synchronous active-low reset empties the table,
// level zero.
module scoped_variable_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int NAME_BYTES    = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [svt_pkg::MODE_W-1:0]          i_mode,
    input  logic [svt_pkg::KEY_W-1:0]           i_name_key,
    input  logic signed [svt_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_found,
    output logic signed [svt_pkg::VALUE_W-1:0]  o_read_value,
    output logic [svt_pkg::STAT_W-1:0]          o_status
);

    svt_pkg::t_cmd  cmd;
    svt_pkg::t_stat stat;

    // sequencer
    svt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // table storage and result registers
    svt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NAME_BYTES    (NAME_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_mode       (i_mode),
        .i_name_key   (i_name_key),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_found      (o_found),
        .o_read_value (o_read_value),
        .o_status     (o_status)
    );

endmodule

/* src/svt_checker.sv */
// svt_checker: port-level assertions for scoped_variable_table
// bound to the top level below; depends on svt_pkg
module svt_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic                                o_found,
    input logic signed [svt_pkg::VALUE_W-1:0]  o_read_value,
    input logic [svt_pkg::STAT_W-1:0]          o_status
);

    // one item in flight: an accepted beat blocks the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in flight");

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a miss or a non-get reads as zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_read_value == '0))
        else $error("nonzero read value without a match");

    // a hit is always a successful get
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_status == svt_pkg::ST_OK))
        else $error("match reported with an error status");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_found) && $stable(o_read_value) &&
             $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind scoped_variable_table svt_checker u_svt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_found      (o_found),
    .o_read_value (o_read_value),
    .o_status     (o_status)
);
